>>> rtl/ssr_pkg.sv
// Shared types and constants for the segment stretch ratio pipeline.
// Used by every module in rtl; depends on nothing else.
`default_nettype none

package ssr_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int STRETCH_W   = 32;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int LEN_W       = SQ_W + 2;
    localparam int Q_W         = 64;
    localparam int DIV_STEPS   = Q_W;
    localparam int ROOT_W      = Q_W / 2;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int SREM_W      = ROOT_W + 3;
    localparam int FRONT_DEPTH = 3;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] left_x;
        logic signed [COORD_WIDTH-1:0] left_y;
        logic signed [COORD_WIDTH-1:0] left_z;
        logic signed [COORD_WIDTH-1:0] right_x;
        logic signed [COORD_WIDTH-1:0] right_y;
        logic signed [COORD_WIDTH-1:0] right_z;
        logic signed [COORD_WIDTH-1:0] ref_left_x;
        logic signed [COORD_WIDTH-1:0] ref_left_y;
        logic signed [COORD_WIDTH-1:0] ref_left_z;
        logic signed [COORD_WIDTH-1:0] ref_right_x;
        logic signed [COORD_WIDTH-1:0] ref_right_y;
        logic signed [COORD_WIDTH-1:0] ref_right_z;
    } seg_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] mid_x;
        logic signed [COORD_WIDTH-1:0] mid_y;
        logic signed [COORD_WIDTH-1:0] mid_z;
        logic        [STRETCH_W-1:0]   stretch;
        logic                          zero_reference;
        logic                          saturated;
    } res_t;

    typedef logic [2:0][COORD_WIDTH-1:0] mid_t;

    typedef struct packed {
        logic zero_ref;
        logic sat;
    } flags_t;

    typedef struct packed {
        logic valid;
        mid_t mid;
        logic [LEN_W-1:0] num;
        logic [LEN_W-1:0] den;
    } front_t;

    typedef struct packed {
        logic   valid;
        mid_t   mid;
        flags_t flags;
        logic [Q_W-1:0] quo;
    } quo_t;

    typedef struct packed {
        logic   valid;
        mid_t   mid;
        flags_t flags;
        logic [ROOT_W-1:0] root;
    } root_t;

endpackage

`default_nettype wire

>>> rtl/ssr_front.sv
// Front stages: differences and midpoints, squares, and squared lengths.
// Three register stages; uses ssr_pkg.
`default_nettype none

module ssr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          seg_valid,
    input  wire ssr_pkg::seg_t seg,
    output ssr_pkg::front_t    front
);

    logic signed [ssr_pkg::COORD_WIDTH-1:0] cl [0:5];
    logic signed [ssr_pkg::COORD_WIDTH-1:0] cr [0:5];
    logic signed [ssr_pkg::DIFF_W-1:0] diff_next [0:5];
    logic signed [ssr_pkg::DIFF_W-1:0] diff_reg [0:5];
    logic [ssr_pkg::DIFF_W-1:0] sum_c [0:2];
    ssr_pkg::mid_t mid_next, mid1_reg, mid2_reg, mid3_reg;
    logic [ssr_pkg::DIFF_W-1:0] mag [0:5];
    logic [ssr_pkg::SQ_W-1:0] sq_next [0:5];
    logic [ssr_pkg::SQ_W-1:0] sq_reg [0:5];
    logic [ssr_pkg::LEN_W-1:0] num_next, den_next, num_reg, den_reg;
    logic v1_reg, v2_reg, v3_reg;

    always_comb
    begin
        cl[0] = seg.left_x;      cr[0] = seg.right_x;
        cl[1] = seg.left_y;      cr[1] = seg.right_y;
        cl[2] = seg.left_z;      cr[2] = seg.right_z;
        cl[3] = seg.ref_left_x;  cr[3] = seg.ref_right_x;
        cl[4] = seg.ref_left_y;  cr[4] = seg.ref_right_y;
        cl[5] = seg.ref_left_z;  cr[5] = seg.ref_right_z;
        for (int i = 0; i < 6; i++)
        begin
            diff_next[i] = ssr_pkg::DIFF_W'(cr[i]) - ssr_pkg::DIFF_W'(cl[i]);
        end
        for (int a = 0; a < 3; a++)
        begin
            sum_c[a] = ssr_pkg::DIFF_W'(cl[a]) + ssr_pkg::DIFF_W'(cr[a]);
            mid_next[a] = sum_c[a][ssr_pkg::DIFF_W-1:1];
        end
        for (int i = 0; i < 6; i++)
        begin
            mag[i] = diff_reg[i][ssr_pkg::DIFF_W-1] ? (~diff_reg[i] + 1'b1) : diff_reg[i];
            sq_next[i] = mag[i] * mag[i];
        end
        num_next = ssr_pkg::LEN_W'(sq_reg[0]) + ssr_pkg::LEN_W'(sq_reg[1])
                 + ssr_pkg::LEN_W'(sq_reg[2]);
        den_next = ssr_pkg::LEN_W'(sq_reg[3]) + ssr_pkg::LEN_W'(sq_reg[4])
                 + ssr_pkg::LEN_W'(sq_reg[5]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= seg_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            mid1_reg <= mid_next;
            sq_reg   <= sq_next;
            mid2_reg <= mid1_reg;
            num_reg  <= num_next;
            den_reg  <= den_next;
            mid3_reg <= mid2_reg;
        end
    end

    assign front.valid = v3_reg;
    assign front.mid   = mid3_reg;
    assign front.num   = num_reg;
    assign front.den   = den_reg;

endmodule

`default_nettype wire

>>> rtl/ssr_div.sv
// Restoring divider, one quotient bit per stage, giving floor(num * 4^F / den).
// One setup stage plus 64 bit stages; uses ssr_pkg.
`default_nettype none

module ssr_div (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire ssr_pkg::front_t front,
    output ssr_pkg::quo_t        quo
);

    localparam int N = ssr_pkg::DIV_STEPS;
    localparam int SH = ssr_pkg::Q_W - 2 * ssr_pkg::FRAC_BITS;

    logic [ssr_pkg::LEN_W-1:0] rem_reg  [0:N];
    logic [ssr_pkg::LEN_W-1:0] den_reg  [0:N];
    logic [ssr_pkg::Q_W-1:0]   feed_reg [0:N];
    logic [ssr_pkg::Q_W-1:0]   q_reg    [0:N];
    ssr_pkg::mid_t             mid_reg  [0:N];
    ssr_pkg::flags_t           fl_reg   [0:N];
    logic                      v_reg    [0:N];

    logic [ssr_pkg::LEN_W-1:0] rem0_next;
    logic [ssr_pkg::Q_W-1:0]   feed0_next;

    assign rem0_next  = front.num >> SH;
    assign feed0_next = ssr_pkg::Q_W'(front.num << (2 * ssr_pkg::FRAC_BITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= front.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]        <= rem0_next;
            den_reg[0]        <= front.den;
            feed_reg[0]       <= feed0_next;
            q_reg[0]          <= '0;
            mid_reg[0]        <= front.mid;
            fl_reg[0].zero_ref <= (front.den == '0);
            fl_reg[0].sat      <= (rem0_next >= front.den);
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_step
        logic [ssr_pkg::LEN_W:0] sh;
        logic                    ge;
        logic [ssr_pkg::LEN_W:0] diff;

        assign sh   = {rem_reg[k-1], feed_reg[k-1][ssr_pkg::Q_W-1]};
        assign ge   = (sh >= {1'b0, den_reg[k-1]});
        assign diff = sh - {1'b0, den_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[ssr_pkg::LEN_W-1:0] : sh[ssr_pkg::LEN_W-1:0];
                den_reg[k]  <= den_reg[k-1];
                feed_reg[k] <= {feed_reg[k-1][ssr_pkg::Q_W-2:0], 1'b0};
                q_reg[k]    <= {q_reg[k-1][ssr_pkg::Q_W-2:0], ge};
                mid_reg[k]  <= mid_reg[k-1];
                fl_reg[k]   <= fl_reg[k-1];
            end
        end
    end

    assign quo.valid = v_reg[N];
    assign quo.mid   = mid_reg[N];
    assign quo.flags = fl_reg[N];
    assign quo.quo   = q_reg[N];

endmodule

`default_nettype wire

>>> rtl/ssr_sqrt.sv
// Digit-by-digit integer square root of the 64-bit quotient, one root bit per stage.
// 32 register stages; uses ssr_pkg.
`default_nettype none

module ssr_sqrt (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire ssr_pkg::quo_t quo,
    output ssr_pkg::root_t     root
);

    localparam int N = ssr_pkg::SQRT_STEPS;
    localparam int RW = ssr_pkg::ROOT_W;
    localparam int SW = ssr_pkg::SREM_W;
    localparam int QW = ssr_pkg::Q_W;

    logic [SW-1:0]   rem_reg [1:N];
    logic [RW-1:0]   rt_reg  [1:N];
    logic [QW-1:0]   q_reg   [1:N];
    ssr_pkg::mid_t   mid_reg [1:N];
    ssr_pkg::flags_t fl_reg  [1:N];
    logic            v_reg   [1:N];

    for (genvar k = 1; k <= N; k++)
    begin : g_step
        logic [SW-1:0]   rem_prev;
        logic [RW-1:0]   rt_prev;
        logic [QW-1:0]   q_prev;
        ssr_pkg::mid_t   mid_prev;
        ssr_pkg::flags_t fl_prev;
        logic            v_prev;
        logic [SW-1:0]   sh;
        logic [SW-1:0]   trial;
        logic            ge;

        if (k == 1)
        begin : g_first
            assign rem_prev = '0;
            assign rt_prev  = '0;
            assign q_prev   = quo.quo;
            assign mid_prev = quo.mid;
            assign fl_prev  = quo.flags;
            assign v_prev   = quo.valid;
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign rt_prev  = rt_reg[k-1];
            assign q_prev   = q_reg[k-1];
            assign mid_prev = mid_reg[k-1];
            assign fl_prev  = fl_reg[k-1];
            assign v_prev   = v_reg[k-1];
        end

        assign sh    = {rem_prev[SW-3:0], q_prev[QW-1:QW-2]};
        assign trial = SW'({rt_prev, 2'b01});
        assign ge    = (sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? (sh - trial) : sh;
                rt_reg[k]  <= {rt_prev[RW-2:0], ge};
                q_reg[k]   <= {q_prev[QW-3:0], 2'b00};
                mid_reg[k] <= mid_prev;
                fl_reg[k]  <= fl_prev;
            end
        end
    end

    assign root.valid = v_reg[N];
    assign root.mid   = mid_reg[N];
    assign root.flags = fl_reg[N];
    assign root.root  = rt_reg[N];

endmodule

`default_nettype wire

>>> rtl/segment_stretch_ratio.sv
// Segment midpoint and stretch ratio, fully pipelined.
// From an accepted beat to its result there are 3 front stages,
// 65 divider stages, 32 square root stages and the output register.
// Throughput is one beat per cycle; a stall on the result freezes the whole pipeline.
// Reset clears the valid bits only; depends on ssr_pkg, ssr_front, ssr_div, ssr_sqrt.
`default_nettype none

module segment_stretch_ratio (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          seg_valid,
    output logic               seg_stall,
    input  wire ssr_pkg::seg_t seg,
    output logic               res_valid,
    input  wire logic          res_stall,
    output ssr_pkg::res_t      res
);

    logic            en;
    ssr_pkg::front_t front;
    ssr_pkg::quo_t   quo;
    ssr_pkg::root_t  root;
    ssr_pkg::res_t   res_next, res_reg;
    logic            valid_reg;

    assign en        = !(valid_reg && res_stall);
    assign seg_stall = !en;

    ssr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .seg_valid (seg_valid),
        .seg       (seg),
        .front     (front)
    );

    ssr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .front (front),
        .quo   (quo)
    );

    ssr_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .quo   (quo),
        .root  (root)
    );

    always_comb
    begin
        res_next.mid_x          = root.mid[0];
        res_next.mid_y          = root.mid[1];
        res_next.mid_z          = root.mid[2];
        res_next.zero_reference = root.flags.zero_ref;
        res_next.saturated      = !root.flags.zero_ref && root.flags.sat;
        if (root.flags.zero_ref)
        begin
            res_next.stretch = '0;
        end
        else if (root.flags.sat)
        begin
            res_next.stretch = '1;
        end
        else
        begin
            res_next.stretch = root.root;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= root.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire
